// ----- hw/rtl/led_pattern_mode_controller_defines.svh -----
// ----------------------------------------------------------------------------
// LED pattern mode controller assertion macros
// Shared concurrent assertion forms for the controller and its checks.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_MODE_CONTROLLER_DEFINES_SVH
`define LED_PATTERN_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPMC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpmc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LPMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpmc assertion failed");

`endif

// ----- hw/rtl/lpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// LED pattern mode controller package
// Types, codes and constants shared by the controller and its interfaces.
// ----------------------------------------------------------------------------
package lpmc_pkg;

  localparam int TIME_WIDTH_DEFAULT = 16;
  localparam int STEP_WIDTH_DEFAULT = 8;

  localparam int KIND_WIDTH  = 4;
  localparam int FIELD_WIDTH = 8;
  localparam int LEVEL_WIDTH = 8;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // Command codes carried in the kind field.
  localparam logic [KIND_WIDTH-1:0] KIND_TICK  = 4'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_ON    = 4'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_OFF   = 4'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_FLASH = 4'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_DIP   = 4'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_BLINK = 4'd5;
  localparam logic [KIND_WIDTH-1:0] KIND_PULSE = 4'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_SLOW  = 4'd7;
  localparam logic [KIND_WIDTH-1:0] KIND_FAST  = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEFAULT_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOW_PERIOD    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAST_PERIOD    = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEFAULT_PERIOD_RESET = 16'd250;
  localparam logic [CFG_WIDTH-1:0] SLOW_PERIOD_RESET    = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] FAST_PERIOD_RESET    = 16'd100;

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_FULL  = 8'd255;
  localparam logic [LEVEL_WIDTH-1:0] BRIGHT_MAX  = 8'd100;
  localparam logic [LEVEL_WIDTH-1:0] BRIGHT_STEP = 8'd8;
  localparam int PULSE_PAUSE_MS = 200;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_ON        = 3'd1,
    MODE_FLASH     = 3'd2,
    MODE_DIP       = 3'd3,
    MODE_BLINK_ON  = 3'd4,
    MODE_BLINK_OFF = 3'd5,
    MODE_PULSE     = 3'd6
  } mode_t;

endpackage

// ----- hw/rtl/lpmc_if.sv -----
// ----------------------------------------------------------------------------
// LED pattern mode controller channels
// Valid/ready channels for commands in and drive status out.
// ----------------------------------------------------------------------------
interface lpmc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [lpmc_pkg::KIND_WIDTH-1:0]     kind;
  logic [lpmc_pkg::FIELD_WIDTH-1:0]    blink_lit_step;
  logic [lpmc_pkg::FIELD_WIDTH-1:0]    blink_cycle_steps;

  modport source (output valid, kind, blink_lit_step, blink_cycle_steps, input ready);
  modport sink   (input valid, kind, blink_lit_step, blink_cycle_steps, output ready);
endinterface

interface lpmc_status_if;
  logic                                valid;
  logic                                ready;
  logic [lpmc_pkg::LEVEL_WIDTH-1:0]    drive_level;
  logic                                pin_high;

  modport source (output valid, drive_level, pin_high, input ready);
  modport sink   (input valid, drive_level, pin_high, output ready);
endinterface

// ----- hw/rtl/led_pattern_mode_controller.sv -----
// ----------------------------------------------------------------------------
// LED pattern mode controller
// Turns a stream of millisecond ticks and mode commands into an LED level.
// ----------------------------------------------------------------------------
// Every command transfer yields exactly one status item, which is offered on
// the status channel from the next cycle on, and a new command is taken in
// every cycle while the status register is empty or being drained, so the
// block sustains one item per clock. The figure is set by the update path
// that reads the mode state, applies the command and the phase
// evaluation, and writes both the state and the status register at the same
// edge. A stalled status transfer holds the command channel off until the
// status is taken.
`include "led_pattern_mode_controller_defines.svh"

module led_pattern_mode_controller #(
  parameter int TIME_WIDTH = lpmc_pkg::TIME_WIDTH_DEFAULT,
  parameter int STEP_WIDTH = lpmc_pkg::STEP_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  lpmc_cmd_if.sink                               cmd,
  lpmc_status_if.source                          status,
  input  logic                                   cfg_write,
  input  logic [lpmc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [lpmc_pkg::CFG_WIDTH-1:0]         cfg_data
);

  // Configuration registers.
  logic [lpmc_pkg::CFG_WIDTH-1:0] default_period_ms;
  logic [lpmc_pkg::CFG_WIDTH-1:0] slow_period_ms;
  logic [lpmc_pkg::CFG_WIDTH-1:0] fast_period_ms;

  // Pattern state and its next values.
  lpmc_pkg::mode_t                  mode, mode_next;
  logic [TIME_WIDTH-1:0]            elapsed_ms, elapsed_ms_next;
  logic [TIME_WIDTH-1:0]            period_ms, period_ms_next;
  logic [STEP_WIDTH-1:0]            blink_step, blink_step_next;
  logic [STEP_WIDTH-1:0]            blink_lit, blink_lit_next;
  logic [STEP_WIDTH-1:0]            blink_count, blink_count_next;
  logic [lpmc_pkg::LEVEL_WIDTH-1:0] brightness, brightness_next;
  logic                             ramp_down, ramp_down_next;
  logic [lpmc_pkg::LEVEL_WIDTH-1:0] drive_value, drive_value_next;
  logic                             level_high, level_high_next;
  logic                             evaluate;

  // Status output register.
  logic                             status_valid;
  logic [lpmc_pkg::LEVEL_WIDTH-1:0] status_level;
  logic                             status_pin;

  logic cmd_transfer;

  // The command side is open whenever the status register is free or is
  // being emptied in this same cycle.
  assign cmd.ready     = !status_valid || status.ready;
  assign cmd_transfer  = cmd.valid && cmd.ready;

  assign status.valid       = status_valid;
  assign status.drive_level = status_level;
  assign status.pin_high    = status_pin;

  // Command decode followed by the phase evaluation. The evaluation sees
  // the state as the command left it, so both read the staged next values.
  always_comb begin
    mode_next        = mode;
    elapsed_ms_next  = elapsed_ms;
    period_ms_next   = period_ms;
    blink_step_next  = blink_step;
    blink_lit_next   = blink_lit;
    blink_count_next = blink_count;
    brightness_next  = brightness;
    ramp_down_next   = ramp_down;
    drive_value_next = drive_value;
    level_high_next  = level_high;
    evaluate         = 1'b0;

    unique case (cmd.kind)
      lpmc_pkg::KIND_TICK: begin
        // Elapsed time saturates rather than wrapping.
        if (elapsed_ms != '1) begin
          elapsed_ms_next = elapsed_ms + TIME_WIDTH'(1);
        end
        evaluate = 1'b1;
      end
      lpmc_pkg::KIND_ON: begin
        mode_next = lpmc_pkg::MODE_ON;
        evaluate  = 1'b1;
      end
      lpmc_pkg::KIND_OFF: begin
        mode_next = lpmc_pkg::MODE_OFF;
        evaluate  = 1'b1;
      end
      lpmc_pkg::KIND_FLASH: begin
        level_high_next  = 1'b1;
        drive_value_next = lpmc_pkg::LEVEL_FULL;
        mode_next        = lpmc_pkg::MODE_FLASH;
        elapsed_ms_next  = '0;
        period_ms_next   = TIME_WIDTH'(default_period_ms);
        evaluate         = 1'b1;
      end
      lpmc_pkg::KIND_DIP: begin
        level_high_next  = 1'b0;
        drive_value_next = '0;
        mode_next        = lpmc_pkg::MODE_DIP;
        elapsed_ms_next  = '0;
        period_ms_next   = TIME_WIDTH'(default_period_ms);
        evaluate         = 1'b1;
      end
      lpmc_pkg::KIND_BLINK: begin
        // Blink restarts the phase timer as well as the step count.
        blink_lit_next   = STEP_WIDTH'(cmd.blink_lit_step);
        blink_count_next = STEP_WIDTH'(cmd.blink_cycle_steps);
        blink_step_next  = STEP_WIDTH'(1);
        mode_next        = lpmc_pkg::MODE_BLINK_ON;
        elapsed_ms_next  = '0;
        period_ms_next   = TIME_WIDTH'(default_period_ms);
        evaluate         = 1'b1;
      end
      lpmc_pkg::KIND_PULSE: begin
        // Pulse starts a fresh ramp but leaves the timer and outputs alone.
        mode_next       = lpmc_pkg::MODE_PULSE;
        brightness_next = '0;
        ramp_down_next  = 1'b0;
        period_ms_next  = TIME_WIDTH'(1);
      end
      lpmc_pkg::KIND_SLOW: begin
        period_ms_next = TIME_WIDTH'(slow_period_ms);
      end
      lpmc_pkg::KIND_FAST: begin
        period_ms_next = TIME_WIDTH'(fast_period_ms);
      end
      default: begin
        // Unused codes leave everything as it is.
      end
    endcase

    if (evaluate) begin
      unique case (mode_next)
        lpmc_pkg::MODE_FLASH: begin
          if (elapsed_ms_next > period_ms_next) begin
            level_high_next  = 1'b0;
            drive_value_next = '0;
            mode_next        = lpmc_pkg::MODE_OFF;
          end
        end
        lpmc_pkg::MODE_DIP: begin
          if (elapsed_ms_next > period_ms_next) begin
            level_high_next  = 1'b1;
            drive_value_next = lpmc_pkg::LEVEL_FULL;
            mode_next        = lpmc_pkg::MODE_ON;
          end
        end
        lpmc_pkg::MODE_BLINK_ON: begin
          // Only the selected step of the cycle lights; the end of the lit
          // phase always turns the LED off.
          if (blink_step_next == blink_lit_next) begin
            level_high_next  = 1'b1;
            drive_value_next = lpmc_pkg::LEVEL_FULL;
          end
          if (elapsed_ms_next > period_ms_next) begin
            level_high_next  = 1'b0;
            drive_value_next = '0;
            mode_next        = lpmc_pkg::MODE_BLINK_OFF;
            elapsed_ms_next  = '0;
          end
        end
        lpmc_pkg::MODE_BLINK_OFF: begin
          if (elapsed_ms_next > period_ms_next) begin
            mode_next       = lpmc_pkg::MODE_BLINK_ON;
            elapsed_ms_next = '0;
            if (blink_step_next >= blink_count_next) begin
              blink_step_next = STEP_WIDTH'(1);
            end else begin
              blink_step_next = blink_step_next + STEP_WIDTH'(1);
            end
          end
        end
        lpmc_pkg::MODE_PULSE: begin
          // One ramp step per expired period; the bottom of the ramp holds
          // for the pause length before climbing again.
          if (elapsed_ms_next > period_ms_next) begin
            elapsed_ms_next = '0;
            period_ms_next  = TIME_WIDTH'(1);
            if (!ramp_down_next) begin
              if (brightness_next + lpmc_pkg::BRIGHT_STEP >= lpmc_pkg::BRIGHT_MAX) begin
                brightness_next = lpmc_pkg::BRIGHT_MAX;
                ramp_down_next  = 1'b1;
              end else begin
                brightness_next = brightness_next + lpmc_pkg::BRIGHT_STEP;
              end
            end else if (brightness_next <= lpmc_pkg::BRIGHT_STEP) begin
              brightness_next = '0;
              period_ms_next  = TIME_WIDTH'(lpmc_pkg::PULSE_PAUSE_MS);
              ramp_down_next  = 1'b0;
            end else begin
              brightness_next = brightness_next - lpmc_pkg::BRIGHT_STEP;
            end
          end
          drive_value_next = brightness_next;
        end
        lpmc_pkg::MODE_ON: begin
          level_high_next  = 1'b1;
          drive_value_next = lpmc_pkg::LEVEL_FULL;
        end
        default: begin
          level_high_next  = 1'b0;
          drive_value_next = '0;
        end
      endcase
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_period_ms <= lpmc_pkg::DEFAULT_PERIOD_RESET;
      slow_period_ms    <= lpmc_pkg::SLOW_PERIOD_RESET;
      fast_period_ms    <= lpmc_pkg::FAST_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lpmc_pkg::REG_DEFAULT_PERIOD: default_period_ms <= cfg_data;
        lpmc_pkg::REG_SLOW_PERIOD:    slow_period_ms    <= cfg_data;
        lpmc_pkg::REG_FAST_PERIOD:    fast_period_ms    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pattern state advances only on a command transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= lpmc_pkg::MODE_OFF;
      elapsed_ms  <= '0;
      period_ms   <= '0;
      blink_step  <= STEP_WIDTH'(1);
      blink_lit   <= STEP_WIDTH'(1);
      blink_count <= STEP_WIDTH'(1);
      brightness  <= '0;
      ramp_down   <= 1'b0;
      drive_value <= '0;
      level_high  <= 1'b0;
    end else if (cmd_transfer) begin
      mode        <= mode_next;
      elapsed_ms  <= elapsed_ms_next;
      period_ms   <= period_ms_next;
      blink_step  <= blink_step_next;
      blink_lit   <= blink_lit_next;
      blink_count <= blink_count_next;
      brightness  <= brightness_next;
      ramp_down   <= ramp_down_next;
      drive_value <= drive_value_next;
      level_high  <= level_high_next;
    end
  end

  // Status register: loaded with the post-command outputs on each command
  // transfer, emptied when the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (cmd_transfer) begin
      status_valid <= 1'b1;
    end else if (status.ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_transfer) begin
      status_level <= drive_value_next;
      status_pin   <= level_high_next;
    end
  end

  `LPMC_ASSERT_NOW(a_stall_blocks_cmd, clk, rst, status.valid && !status.ready, !cmd.ready)
  `LPMC_ASSERT_NEXT(a_cmd_gives_status, clk, rst, cmd.valid && cmd.ready, status.valid)
  `LPMC_ASSERT_NOW(a_pulse_in_range, clk, rst, mode == lpmc_pkg::MODE_PULSE, brightness <= lpmc_pkg::BRIGHT_MAX)

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern mode controller testbench
// Drives ticks and mode commands through the command channel and checks each
// status transfer against a cycle-free model of the controller kept here.
// The run opens with a short table of directed items, then runs several
// random phases under different period register settings. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  // Kinds that carry no command. The block must leave its state alone.
  localparam logic [lpmc_pkg::KIND_WIDTH-1:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [lpmc_pkg::KIND_WIDTH-1:0] KIND_UNUSED_HI = 4'd15;

  localparam int PHASE_ITEMS    = 95;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [lpmc_pkg::LEVEL_WIDTH-1:0] drive_level;
    logic                             pin_high;
  } led_status_t;

  // One row of the directed table. Where "typed" is set, the status is
  // written in by hand; elsewhere the model below supplies it.
  typedef struct packed {
    logic [lpmc_pkg::KIND_WIDTH-1:0]  kind;
    logic [lpmc_pkg::FIELD_WIDTH-1:0] lit_step;
    logic [lpmc_pkg::FIELD_WIDTH-1:0] cycle_steps;
    logic                             typed;
    logic [lpmc_pkg::LEVEL_WIDTH-1:0] drive_level;
    logic                             pin_high;
  } plan_row_t;

  logic clk;
  logic rst;
  logic                                 cfg_write;
  logic [lpmc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [lpmc_pkg::CFG_WIDTH-1:0]       cfg_data;

  lpmc_cmd_if    cmd_ch();
  lpmc_status_if status_ch();

  led_pattern_mode_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .status    (status_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The directed table. It starts from the reset registers (period 250),
  // walks every command, both unused-kind extremes, the zero blink
  // selection, and the pulse command leaving the pin level alone.
  plan_row_t directed_plan [0:19] = '{
    '{lpmc_pkg::KIND_TICK,  8'h00, 8'h00, 1'b1, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_ON,    8'h00, 8'h00, 1'b1, 8'd255, 1'b1},
    '{KIND_UNUSED_HI,       8'hFF, 8'hFF, 1'b1, 8'd255, 1'b1},
    '{lpmc_pkg::KIND_OFF,   8'h00, 8'h00, 1'b1, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_FLASH, 8'h00, 8'h00, 1'b1, 8'd255, 1'b1},
    '{lpmc_pkg::KIND_TICK,  8'h00, 8'h00, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_DIP,   8'h00, 8'h00, 1'b1, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_BLINK, 8'h00, 8'h00, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_BLINK, 8'h01, 8'hFF, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_BLINK, 8'hFF, 8'h01, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_PULSE, 8'h00, 8'h00, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_TICK,  8'h00, 8'h00, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_TICK,  8'hFF, 8'hFF, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_SLOW,  8'h00, 8'h00, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_TICK,  8'h00, 8'h00, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_FAST,  8'hFF, 8'hFF, 1'b0, 8'd0,   1'b0},
    '{KIND_UNUSED_LO,       8'h00, 8'h00, 1'b0, 8'd0,   1'b0},
    '{lpmc_pkg::KIND_ON,    8'h00, 8'h00, 1'b1, 8'd255, 1'b1},
    '{KIND_UNUSED_HI,       8'h00, 8'h00, 1'b1, 8'd255, 1'b1},
    '{lpmc_pkg::KIND_OFF,   8'hAA, 8'h55, 1'b1, 8'd0,   1'b0}
  };

  // Register settings for the random phases: default, slow, fast. Short
  // periods let blink and pulse cycle many times; the extremes are here too.
  logic [lpmc_pkg::CFG_WIDTH-1:0] phase_periods [0:3][0:2] = '{
    '{16'd2,     16'd7,     16'd1},
    '{16'd0,     16'hFFFF,  16'd0},
    '{16'hFFFF,  16'd0,     16'd3},
    '{16'd5,     16'd12,    16'd2}
  };

  // Model state of the controller and its registers.
  lpmc_pkg::mode_t                  led_mode;
  logic [15:0]                      elapsed_ms;
  logic [15:0]                      period_ms;
  logic [7:0]                       blink_step;
  logic [7:0]                       blink_lit;
  logic [7:0]                       blink_count;
  logic [7:0]                       brightness;
  logic                             ramp_down;
  logic [lpmc_pkg::LEVEL_WIDTH-1:0] drive_value;
  logic                             level_high;
  logic [lpmc_pkg::CFG_WIDTH-1:0]   default_period;
  logic [lpmc_pkg::CFG_WIDTH-1:0]   slow_period;
  logic [lpmc_pkg::CFG_WIDTH-1:0]   fast_period;

  // Statuses the block still owes, oldest first.
  led_status_t status_due [$];
  int          mismatch_count;

  // Idling switches for the command side and the status side.
  bit cmd_idling;
  bit status_idling;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Generous run limit.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Most gaps are zero or short, a few are long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void set_drive(logic lit);
    level_high  = lit;
    drive_value = lit ? lpmc_pkg::LEVEL_FULL : '0;
  endfunction

  // Phase evaluation. A phase is over once the elapsed time has passed the
  // period, not merely reached it.
  function automatic void evaluate_mode();
    logic over;
    over = elapsed_ms > period_ms;
    case (led_mode)
      lpmc_pkg::MODE_FLASH: begin
        if (over) begin
          set_drive(1'b0);
          led_mode = lpmc_pkg::MODE_OFF;
        end
      end
      lpmc_pkg::MODE_DIP: begin
        if (over) begin
          set_drive(1'b1);
          led_mode = lpmc_pkg::MODE_ON;
        end
      end
      lpmc_pkg::MODE_BLINK_ON: begin
        if (blink_step == blink_lit) set_drive(1'b1);
        if (over) begin
          set_drive(1'b0);
          led_mode   = lpmc_pkg::MODE_BLINK_OFF;
          elapsed_ms = '0;
        end
      end
      lpmc_pkg::MODE_BLINK_OFF: begin
        if (over) begin
          led_mode   = lpmc_pkg::MODE_BLINK_ON;
          elapsed_ms = '0;
          if (blink_step >= blink_count) blink_step = 8'd1;
          else blink_step = blink_step + 8'd1;
        end
      end
      lpmc_pkg::MODE_PULSE: begin
        if (over) begin
          elapsed_ms = '0;
          period_ms  = 16'd1;
          if (!ramp_down) begin
            brightness = brightness + lpmc_pkg::BRIGHT_STEP;
            if (brightness >= lpmc_pkg::BRIGHT_MAX) begin
              brightness = lpmc_pkg::BRIGHT_MAX;
              ramp_down  = 1'b1;
            end
          end else if (brightness <= lpmc_pkg::BRIGHT_STEP) begin
            // Bottom of the ramp: hold dark for the long pause.
            brightness = '0;
            period_ms  = 16'(lpmc_pkg::PULSE_PAUSE_MS);
            ramp_down  = 1'b0;
          end else begin
            brightness = brightness - lpmc_pkg::BRIGHT_STEP;
          end
        end
        drive_value = brightness;
      end
      lpmc_pkg::MODE_ON: set_drive(1'b1);
      default: set_drive(1'b0);
    endcase
  endfunction

  // Applies one command transfer to the model and returns the status the
  // block must send for it.
  function automatic led_status_t advance_led(
      logic [lpmc_pkg::KIND_WIDTH-1:0]  kind,
      logic [lpmc_pkg::FIELD_WIDTH-1:0] lit_step,
      logic [lpmc_pkg::FIELD_WIDTH-1:0] cycle_steps);
    led_status_t result;
    case (kind)
      lpmc_pkg::KIND_TICK: begin
        if (elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 16'd1;
        evaluate_mode();
      end
      lpmc_pkg::KIND_ON: begin
        led_mode = lpmc_pkg::MODE_ON;
        evaluate_mode();
      end
      lpmc_pkg::KIND_OFF: begin
        led_mode = lpmc_pkg::MODE_OFF;
        evaluate_mode();
      end
      lpmc_pkg::KIND_FLASH: begin
        set_drive(1'b1);
        led_mode   = lpmc_pkg::MODE_FLASH;
        elapsed_ms = '0;
        period_ms  = default_period;
        evaluate_mode();
      end
      lpmc_pkg::KIND_DIP: begin
        set_drive(1'b0);
        led_mode   = lpmc_pkg::MODE_DIP;
        elapsed_ms = '0;
        period_ms  = default_period;
        evaluate_mode();
      end
      lpmc_pkg::KIND_BLINK: begin
        blink_lit   = lit_step;
        blink_count = cycle_steps;
        blink_step  = 8'd1;
        led_mode    = lpmc_pkg::MODE_BLINK_ON;
        elapsed_ms  = '0;
        period_ms   = default_period;
        evaluate_mode();
      end
      lpmc_pkg::KIND_PULSE: begin
        // The pulse command leaves the timer running on purpose.
        led_mode   = lpmc_pkg::MODE_PULSE;
        brightness = '0;
        ramp_down  = 1'b0;
        period_ms  = 16'd1;
      end
      lpmc_pkg::KIND_SLOW: period_ms = slow_period;
      lpmc_pkg::KIND_FAST: period_ms = fast_period;
      default: ;
    endcase
    result.drive_level = drive_value;
    result.pin_high    = level_high;
    return result;
  endfunction

  // Register write on the configuration port, mirrored into the model.
  task automatic write_period(logic [lpmc_pkg::CFG_INDEX_WIDTH-1:0] index,
                              logic [lpmc_pkg::CFG_WIDTH-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    case (index)
      lpmc_pkg::REG_DEFAULT_PERIOD: default_period = value;
      lpmc_pkg::REG_SLOW_PERIOD:    slow_period    = value;
      lpmc_pkg::REG_FAST_PERIOD:    fast_period    = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Sends one command. Inputs change only at falling edges; the transfer is
  // seen at the rising edge where valid and ready are both high. A zero gap
  // keeps valid high straight into the next item.
  task automatic send_cmd(logic [lpmc_pkg::KIND_WIDTH-1:0] kind,
                          logic [lpmc_pkg::FIELD_WIDTH-1:0] lit_step,
                          logic [lpmc_pkg::FIELD_WIDTH-1:0] cycle_steps,
                          logic typed = 1'b0,
                          led_status_t typed_status = '0);
    int          gap;
    led_status_t predicted;
    gap = cmd_idling ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid             = 1'b1;
    cmd_ch.kind              = kind;
    cmd_ch.blink_lit_step    = lit_step;
    cmd_ch.blink_cycle_steps = cycle_steps;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    predicted = advance_led(kind, lit_step, cycle_steps);
    status_due.push_back(typed ? typed_status : predicted);
  endtask

  // Waits until every owed status has arrived, then lets the pipeline settle
  // before the registers are touched.
  task automatic wait_idle();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Status side: ready drops for random stretches while idling is enabled.
  initial begin
    int stall_left;
    stall_left      = 0;
    status_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && status_idling && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        status_ch.ready = 1'b0;
        stall_left--;
      end else begin
        status_ch.ready = 1'b1;
      end
    end
  end

  // Every status transfer is matched against the oldest owed status.
  always @(posedge clk) begin
    led_status_t want;
    if (rst === 1'b0 && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("status transfer with nothing owed (level %0d pin %0b)",
                                  status_ch.drive_level, status_ch.pin_high));
      end else begin
        want = status_due.pop_front();
        if (status_ch.drive_level !== want.drive_level) begin
          report_mismatch($sformatf("drive_level got %0d, want %0d",
                                    status_ch.drive_level, want.drive_level));
        end
        if (status_ch.pin_high !== want.pin_high) begin
          report_mismatch($sformatf("pin_high got %0b, want %0b",
                                    status_ch.pin_high, want.pin_high));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int                               row;
    int                               phase;
    int                               sent;
    int                               burst;
    int                               roll;
    logic [lpmc_pkg::KIND_WIDTH-1:0]  kind;
    logic [lpmc_pkg::FIELD_WIDTH-1:0] lit_step;
    logic [lpmc_pkg::FIELD_WIDTH-1:0] cycle_steps;

    mismatch_count = 0;
    cmd_idling     = 1'b0;
    status_idling  = 1'b0;

    rst                      = 1'b1;
    cfg_write                = 1'b0;
    cfg_index                = lpmc_pkg::REG_DEFAULT_PERIOD;
    cfg_data                 = '0;
    cmd_ch.valid             = 1'b0;
    cmd_ch.kind              = lpmc_pkg::KIND_TICK;
    cmd_ch.blink_lit_step    = '0;
    cmd_ch.blink_cycle_steps = '0;

    // Model state after reset.
    led_mode       = lpmc_pkg::MODE_OFF;
    elapsed_ms     = '0;
    period_ms      = '0;
    blink_step     = 8'd1;
    blink_lit      = 8'd1;
    blink_count    = 8'd1;
    brightness     = '0;
    ramp_down      = 1'b0;
    drive_value    = '0;
    level_high     = 1'b0;
    default_period = lpmc_pkg::DEFAULT_PERIOD_RESET;
    slow_period    = lpmc_pkg::SLOW_PERIOD_RESET;
    fast_period    = lpmc_pkg::FAST_PERIOD_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, run with idling on both sides.
    cmd_idling    = 1'b1;
    status_idling = 1'b1;
    for (row = 0; row < 20; row++) begin
      send_cmd(directed_plan[row].kind, directed_plan[row].lit_step,
               directed_plan[row].cycle_steps, directed_plan[row].typed,
               {directed_plan[row].drive_level, directed_plan[row].pin_high});
    end

    // Random phases. Each opens with a fresh register setting, written while
    // the block is idle. Commands are followed by bursts of ticks so that
    // flash, dip, blink and pulse get to run through their phases.
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_period(lpmc_pkg::REG_DEFAULT_PERIOD, phase_periods[phase][0]);
      write_period(lpmc_pkg::REG_SLOW_PERIOD,    phase_periods[phase][1]);
      write_period(lpmc_pkg::REG_FAST_PERIOD,    phase_periods[phase][2]);
      cmd_idling    = 1'b1;
      status_idling = (phase != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          kind = lpmc_pkg::KIND_WIDTH'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end else begin
          kind = lpmc_pkg::KIND_WIDTH'($urandom_range(lpmc_pkg::KIND_ON,
                                                      lpmc_pkg::KIND_FAST));
        end
        if ($urandom_range(0, 3) != 0) begin
          lit_step    = lpmc_pkg::FIELD_WIDTH'($urandom_range(0, 4));
          cycle_steps = lpmc_pkg::FIELD_WIDTH'($urandom_range(0, 4));
        end else begin
          lit_step    = lpmc_pkg::FIELD_WIDTH'($urandom);
          cycle_steps = lpmc_pkg::FIELD_WIDTH'($urandom);
        end
        send_cmd(kind, lit_step, cycle_steps);
        sent++;
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                            : $urandom_range(0, 12);
        repeat (burst) begin
          send_cmd(lpmc_pkg::KIND_TICK, lpmc_pkg::FIELD_WIDTH'($urandom),
                   lpmc_pkg::FIELD_WIDTH'($urandom));
        end
        sent += burst;
      end
    end

    // Drain: every owed status must arrive, then a quiet stretch of
    // DRAIN_CYCLES catches any stray transfer.
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && status_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
